FILE: hdl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);
   localparam int SHF_WIDTH  = $clog2(DATA_WIDTH);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_FORM,
      S_NORM,
      S_CHECK,
      S_GCD,
      S_GFIN,
      S_DIVN_LOAD,
      S_DIVN,
      S_DIVD_LOAD,
      S_DIVD,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL0,
      CMD_MUL1,
      CMD_MUL2,
      CMD_FORM,
      CMD_NORM,
      CMD_GINIT,
      CMD_GSTEP,
      CMD_GFIN,
      CMD_DIVN_LOAD,
      CMD_DIVD_LOAD,
      CMD_DIV_STEP,
      CMD_DIVN_SAVE,
      CMD_DIVD_SAVE,
      CMD_PUBLISH
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic skip_reduce;
      logic gcd_done;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: hdl/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::dp_cmd_type    cmd
);

   rau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.code   = rau_pkg::CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         rau_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.code = rau_pkg::CMD_LOAD;
               state_in = rau_pkg::S_MUL0;
            end
         end
         rau_pkg::S_MUL0: begin
            cmd.code = rau_pkg::CMD_MUL0;
            state_in = rau_pkg::S_MUL1;
         end
         rau_pkg::S_MUL1: begin
            cmd.code = rau_pkg::CMD_MUL1;
            state_in = rau_pkg::S_MUL2;
         end
         rau_pkg::S_MUL2: begin
            cmd.code = rau_pkg::CMD_MUL2;
            state_in = rau_pkg::S_FORM;
         end
         rau_pkg::S_FORM: begin
            cmd.code = rau_pkg::CMD_FORM;
            state_in = rau_pkg::S_NORM;
         end
         rau_pkg::S_NORM: begin
            cmd.code = rau_pkg::CMD_NORM;
            state_in = rau_pkg::S_CHECK;
         end
         rau_pkg::S_CHECK: begin
            if (status.skip_reduce) begin
               state_in = rau_pkg::S_OUT;
            end else begin
               cmd.code = rau_pkg::CMD_GINIT;
               state_in = rau_pkg::S_GCD;
            end
         end
         rau_pkg::S_GCD: begin
            if (status.gcd_done) begin
               state_in = rau_pkg::S_GFIN;
            end else begin
               cmd.code = rau_pkg::CMD_GSTEP;
            end
         end
         rau_pkg::S_GFIN: begin
            cmd.code = rau_pkg::CMD_GFIN;
            state_in = rau_pkg::S_DIVN_LOAD;
         end
         rau_pkg::S_DIVN_LOAD: begin
            cmd.code = rau_pkg::CMD_DIVN_LOAD;
            state_in = rau_pkg::S_DIVN;
         end
         rau_pkg::S_DIVN: begin
            if (status.div_done) begin
               cmd.code = rau_pkg::CMD_DIVN_SAVE;
               state_in = rau_pkg::S_DIVD_LOAD;
            end else begin
               cmd.code = rau_pkg::CMD_DIV_STEP;
            end
         end
         rau_pkg::S_DIVD_LOAD: begin
            cmd.code = rau_pkg::CMD_DIVD_LOAD;
            state_in = rau_pkg::S_DIVD;
         end
         rau_pkg::S_DIVD: begin
            if (status.div_done) begin
               cmd.code = rau_pkg::CMD_DIVD_SAVE;
               state_in = rau_pkg::S_OUT;
            end else begin
               cmd.code = rau_pkg::CMD_DIV_STEP;
            end
         end
         rau_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.code = rau_pkg::CMD_PUBLISH;
               state_in = rau_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rau_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/rau_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  rau_pkg::dp_cmd_type                   cmd,
   output rau_pkg::dp_status_type                status,
   input  wire  [4*rau_pkg::DATA_WIDTH-1:0]      req_tdata,
   input  wire  [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [2*rau_pkg::DATA_WIDTH-1:0]      rsp_tdata,
   output logic [0:0]                            rsp_tuser
);

   localparam int DW = rau_pkg::DATA_WIDTH;

   logic [1:0]                      op_ff, op_in;
   logic [DW-1:0]                   an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [DW-1:0]                   p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [DW-1:0]                   n_ff, n_in, d_ff, d_in;
   logic [DW-1:0]                   ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [rau_pkg::SHF_WIDTH-1:0]   gk_ff, gk_in;
   logic [DW:0]                     rem_ff, rem_in;
   logic [DW-1:0]                   quo_ff, quo_in, dvs_ff, dvs_in;
   logic [rau_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   logic [DW-1:0]                   res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                            zero_ff, zero_in;
   logic                            out_valid_ff, out_valid_in;

   logic [DW-1:0]   mul_x, mul_y;
   logic [DW-1:0]   prod;
   logic [DW:0]     rem_shift, rem_sub;

   always_comb begin
      mul_x = an_ff;
      mul_y = bd_ff;
      unique case (cmd.code)
         rau_pkg::CMD_MUL0: begin
            mul_x = an_ff;
            mul_y = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::CMD_MUL1: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         rau_pkg::CMD_MUL2: begin
            mul_x = ad_ff;
            mul_y = bd_ff;
         end
         default: begin
            mul_x = an_ff;
            mul_y = bd_ff;
         end
      endcase
   end

   assign prod      = mul_x * mul_y;
   assign rem_shift = {rem_ff[DW-1:0], quo_ff[DW-1]};
   assign rem_sub   = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      op_in        = op_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      gk_in        = gk_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      zero_in      = zero_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (cmd.code)
         rau_pkg::CMD_LOAD: begin
            op_in = req_tuser;
            an_in = req_tdata[DW-1:0];
            ad_in = req_tdata[2*DW-1:DW];
            bn_in = req_tdata[3*DW-1:2*DW];
            bd_in = req_tdata[4*DW-1:3*DW];
         end
         rau_pkg::CMD_MUL0: p0_in = prod[DW-1:0];
         rau_pkg::CMD_MUL1: p1_in = prod[DW-1:0];
         rau_pkg::CMD_MUL2: p2_in = prod[DW-1:0];
         rau_pkg::CMD_FORM: begin
            case (op_ff)
               rau_pkg::OP_ADD: n_in = p0_ff + p1_ff;
               rau_pkg::OP_SUB: n_in = p0_ff - p1_ff;
               default:         n_in = p0_ff;
            endcase
            d_in = (op_ff == rau_pkg::OP_DIV) ? p1_ff : p2_ff;
         end
         rau_pkg::CMD_NORM: begin
            if (n_ff == '0) begin
               d_in = DW'(1);
            end else if (d_ff[DW-1]) begin
               n_in = '0 - n_ff;
               d_in = '0 - d_ff;
            end
         end
         rau_pkg::CMD_GINIT: begin
            ga_in = n_ff[DW-1] ? ('0 - n_ff) : n_ff;
            gb_in = d_ff;
            gk_in = '0;
         end
         rau_pkg::CMD_GSTEP: begin
            if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = (ga_ff - gb_ff) >> 1;
            end else begin
               gb_in = (gb_ff - ga_ff) >> 1;
            end
         end
         rau_pkg::CMD_GFIN: begin
            g_in = ((ga_ff == '0) ? gb_ff : ga_ff) << gk_ff;
         end
         rau_pkg::CMD_DIVN_LOAD: begin
            rem_in = '0;
            quo_in = n_ff[DW-1] ? ('0 - n_ff) : n_ff;
            dvs_in = g_ff;
            cnt_in = rau_pkg::CNT_WIDTH'(DW);
            neg_in = n_ff[DW-1] ^ g_ff[DW-1];
         end
         rau_pkg::CMD_DIVD_LOAD: begin
            rem_in = '0;
            quo_in = d_ff[DW-1] ? ('0 - d_ff) : d_ff;
            dvs_in = g_ff;
            cnt_in = rau_pkg::CNT_WIDTH'(DW);
            neg_in = d_ff[DW-1] ^ g_ff[DW-1];
         end
         rau_pkg::CMD_DIV_STEP: begin
            if (!rem_sub[DW]) begin
               rem_in = rem_sub;
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         rau_pkg::CMD_DIVN_SAVE: n_in = neg_ff ? ('0 - quo_ff) : quo_ff;
         rau_pkg::CMD_DIVD_SAVE: d_in = neg_ff ? ('0 - quo_ff) : quo_ff;
         rau_pkg::CMD_PUBLISH: begin
            res_num_in   = n_ff;
            res_den_in   = d_ff;
            zero_in      = (d_ff == '0);
            out_valid_in = 1'b1;
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      op_ff      <= op_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      gk_ff      <= gk_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      zero_ff    <= zero_in;
   end

   assign status.skip_reduce = (n_ff == '0) || (n_ff == DW'(1)) || (d_ff == DW'(1));
   assign status.gcd_done    = (ga_ff == '0) || (gb_ff == '0);
   assign status.div_done    = (cnt_ff == '0);
   assign status.out_free    = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_den_ff, res_num_ff};
   assign rsp_tuser  = zero_ff;

endmodule
`default_nettype wire

FILE: hdl/rational_arith_unit.sv
// Rational arithmetic with reduction: each input beat carries two fractions and an
// operation (add, subtract, multiply, divide); products and sums wrap to 32 bits, the
// raw fraction is sign-normalized and reduced by the gcd of its parts, and one result
// beat follows with a flag for a zero denominator. One item is worked at a time; when
// no reduction is needed the gcd and the divisions are skipped, else the work is set by
// the one-bit-a-cycle binary gcd loop (up to 2*32 steps) and the two 32-step restoring
// divisions on the shared divider. A finished result waits in the output register while
// the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [4*rau_pkg::DATA_WIDTH-1:0]   req_tdata,  // a_num, a_den, b_num, b_den
   input  wire  [1:0]                         req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [2*rau_pkg::DATA_WIDTH-1:0]   rsp_tdata,  // res_num, res_den
   output logic [0:0]                         rsp_tuser   // zero_den
);

   rau_pkg::dp_cmd_type    cmd;
   rau_pkg::dp_status_type status;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rau_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
